/* rtl/vtpy_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vtpy_pkg;

  // control that travels beside each vector through the pipe
  typedef struct packed {
    logic vld;
    logic zero_xy;   // x and y both zero
    logic z_pos;     // z above zero
    logic bypass;    // first pass skipped (on an axis after pre-rotation)
  } ctl_t;

  localparam int ANG_W       = 32;  // binary angle, 2^32 is a full turn
  localparam int OUT_W       = 17;
  localparam int OUT_TDATA_W = 40;
  localparam int GUARD_BITS  = 8;
  localparam int GAIN_FRAC   = 22;

  localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q22   = 22'd2547003;
  localparam logic [OUT_W-1:0]     OUT_FULL_CIRCLE = 17'd92160;
  localparam logic [OUT_W-1:0]     PITCH_DOWN      = 17'd69120;  // 270 deg
  localparam logic [OUT_W-1:0]     PITCH_UP        = 17'd23040;  // 90 deg

  localparam logic [ANG_W-1:0] ANGLE_0   = 32'h0000_0000;
  localparam logic [ANG_W-1:0] ANGLE_90  = 32'h4000_0000;
  localparam logic [ANG_W-1:0] ANGLE_180 = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANGLE_270 = 32'hC000_0000;

  // atan(2^-i) in binary angle units
  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

/* rtl/vtpy_cordic_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

// One registered CORDIC vectoring micro-rotation.
module vtpy_cordic_stage #(
  parameter int XW           = 35,
  parameter int AUX_W        = 35,
  parameter int SHIFT        = 0,
  parameter bit HOLD_ON_ZERO = 1'b0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  vtpy_pkg::ctl_t               ctl_i,
  input  wire signed [XW-1:0]          x_i,
  input  wire signed [XW-1:0]          y_i,
  input  wire [vtpy_pkg::ANG_W-1:0]    ang_i,
  input  wire [AUX_W-1:0]              aux_i,
  output vtpy_pkg::ctl_t               ctl_o,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic [vtpy_pkg::ANG_W-1:0]   ang_o,
  output logic [AUX_W-1:0]             aux_o
);
  import vtpy_pkg::*;

  ctl_t                    ctl_r;
  logic signed [XW-1:0]    x_r, y_r, x_nxt, y_nxt;
  logic signed [XW-1:0]    dx, dy;
  logic [ANG_W-1:0]        ang_r, ang_nxt;
  logic [AUX_W-1:0]        aux_r;
  logic                    skip;

  assign dx   = x_i >>> SHIFT;
  assign dy   = y_i >>> SHIFT;
  assign skip = HOLD_ON_ZERO ? (y_i == '0) : ctl_i.bypass;

  always_comb begin
    x_nxt   = x_i;
    y_nxt   = y_i;
    ang_nxt = ang_i;
    if (!skip) begin
      if (!y_i[XW-1]) begin
        x_nxt   = x_i + dy;
        y_nxt   = y_i - dx;
        ang_nxt = ang_i + ATAN_TAB[SHIFT];
      end else begin
        x_nxt   = x_i - dy;
        y_nxt   = y_i + dx;
        ang_nxt = ang_i - ATAN_TAB[SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
      aux_r <= aux_i;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign ang_o = ang_r;
  assign aux_o = aux_r;

endmodule

`default_nettype wire

/* rtl/vtpy_gain_comp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Planar length = x * (1/K) >> 22 (x as is on bypass), split in two half-width products.
module vtpy_gain_comp #(
  parameter int XW    = 35,
  parameter int AUX_W = 35
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  vtpy_pkg::ctl_t               ctl_i,
  input  wire signed [XW-1:0]          x_i,
  input  wire [vtpy_pkg::ANG_W-1:0]    ang_i,
  input  wire [AUX_W-1:0]              aux_i,
  output vtpy_pkg::ctl_t               ctl_o,
  output logic signed [XW-1:0]         len_o,
  output logic [vtpy_pkg::ANG_W-1:0]   ang_o,
  output logic [AUX_W-1:0]             aux_o
);
  import vtpy_pkg::*;

  localparam int MAG_W = XW - 1;   // x is never negative here
  localparam int LO_W  = MAG_W / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int SUM_W = MAG_W + GAIN_FRAC;

  ctl_t                      ctla_r, ctlb_r;
  logic [LO_W+GAIN_FRAC-1:0] plo_r, plo_nxt;
  logic [HI_W+GAIN_FRAC-1:0] phi_r, phi_nxt;
  logic signed [XW-1:0]      xa_r, len_r, len_nxt;
  logic [ANG_W-1:0]          anga_r, angb_r;
  logic [AUX_W-1:0]          auxa_r, auxb_r;
  logic [SUM_W-1:0]          sum;

  assign plo_nxt = {{GAIN_FRAC{1'b0}}, x_i[LO_W-1:0]} * {{LO_W{1'b0}}, INV_GAIN_Q22};
  assign phi_nxt = {{GAIN_FRAC{1'b0}}, x_i[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, INV_GAIN_Q22};

  assign sum = {phi_r, {LO_W{1'b0}}} + {{HI_W{1'b0}}, plo_r};

  always_comb begin
    if (ctla_r.bypass) begin
      len_nxt = xa_r;
    end else begin
      len_nxt = {1'b0, sum[SUM_W-1:GAIN_FRAC]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r <= '0;
      ctlb_r <= '0;
    end else if (en) begin
      ctla_r <= ctl_i;
      ctlb_r <= ctla_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      xa_r   <= x_i;
      anga_r <= ang_i;
      auxa_r <= aux_i;
      len_r  <= len_nxt;
      angb_r <= anga_r;
      auxb_r <= auxa_r;
    end
  end

  assign ctl_o = ctlb_r;
  assign len_o = len_r;
  assign ang_o = angb_r;
  assign aux_o = auxb_r;

endmodule

`default_nettype wire

/* rtl/vtpy_angle_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

// Binary angle to 1/256 degree: (ang * 92160) >> 32, plus the zero-plane case.
module vtpy_angle_scale (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  vtpy_pkg::ctl_t               ctl_i,
  input  wire [vtpy_pkg::ANG_W-1:0]    pitch_ang_i,
  input  wire [vtpy_pkg::ANG_W-1:0]    yaw_ang_i,
  output vtpy_pkg::ctl_t               ctl_o,
  output logic [vtpy_pkg::OUT_W-1:0]   pitch_o,
  output logic [vtpy_pkg::OUT_W-1:0]   yaw_o
);
  import vtpy_pkg::*;

  localparam int PROD_W = ANG_W + OUT_W;

  ctl_t              ctl_r;
  logic [PROD_W-1:0] pitch_prod_r, yaw_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_prod_r <= {{OUT_W{1'b0}}, pitch_ang_i} * {{ANG_W{1'b0}}, OUT_FULL_CIRCLE};
      yaw_prod_r   <= {{OUT_W{1'b0}}, yaw_ang_i} * {{ANG_W{1'b0}}, OUT_FULL_CIRCLE};
    end
  end

  always_comb begin
    if (ctl_r.zero_xy) begin
      pitch_o = ctl_r.z_pos ? PITCH_DOWN : PITCH_UP;
      yaw_o   = '0;
    end else begin
      pitch_o = pitch_prod_r[PROD_W-1:ANG_W];
      yaw_o   = yaw_prod_r[PROD_W-1:ANG_W];
    end
  end

  assign ctl_o = ctl_r;

endmodule

`default_nettype wire

/* rtl/vector_to_pitch_yaw.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input to out_tvalid: input register, both CORDIC passes, gain correction, scale and
// output registers. Throughput: one request per cycle while the skid entry is empty; every
// stage of both CORDIC passes is registered. A two-entry output (register plus skid) keeps
// in_tready registered and lets input flow while a result waits. Synchronous active-low
// reset clears all valid bits, no clearing pass; in_tready is low in reset, up on release.
module vector_to_pitch_yaw #(
  parameter int COMPONENT_WIDTH = 24,
  parameter int CORDIC_STAGES   = 24,
  localparam int IN_TDATA_W     = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [IN_TDATA_W-1:0]               in_tdata,   // vec_x, vec_y, vec_z
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [vtpy_pkg::OUT_TDATA_W-1:0]   out_tdata   // pitch, yaw
);
  import vtpy_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int N  = CORDIC_STAGES;
  // guard bits, sign, and headroom for CORDIC gain times sqrt(3)
  localparam int XW = W + GUARD_BITS + 3;

  // ------------------------------------------------------------------
  // Global stall: the whole pipe moves unless the skid entry is taken.
  // ------------------------------------------------------------------
  logic en;
  logic skid_valid_r;
  assign en        = !skid_valid_r;
  assign in_tready = en && rst_n;

  // ------------------------------------------------------------------
  // Input unpack and quadrant pre-rotation into the right half-plane
  // ------------------------------------------------------------------
  logic signed [W-1:0]  vx, vy, vz;
  logic signed [XW-1:0] xs, ys, zs;
  logic signed [XW-1:0] pre_x, pre_y;
  logic [ANG_W-1:0]     pre_ang;
  ctl_t                 pre_ctl;

  assign vx = in_tdata[W-1:0];
  assign vy = in_tdata[2*W-1:W];
  assign vz = in_tdata[3*W-1:2*W];

  assign xs = {{(XW-W-GUARD_BITS){vx[W-1]}}, vx, {GUARD_BITS{1'b0}}};
  assign ys = {{(XW-W-GUARD_BITS){vy[W-1]}}, vy, {GUARD_BITS{1'b0}}};
  assign zs = {{(XW-W-GUARD_BITS){vz[W-1]}}, vz, {GUARD_BITS{1'b0}}};

  always_comb begin
    if (ys > 0) begin            // turn by -90
      pre_x   = ys;
      pre_y   = -xs;
      pre_ang = ANGLE_90;
    end else if (ys < 0) begin   // turn by +90
      pre_x   = -ys;
      pre_y   = xs;
      pre_ang = ANGLE_270;
    end else if (xs < 0) begin   // negative x axis
      pre_x   = -xs;
      pre_y   = ys;
      pre_ang = ANGLE_180;
    end else begin
      pre_x   = xs;
      pre_y   = ys;
      pre_ang = ANGLE_0;
    end
    pre_ctl.vld     = in_tvalid;
    pre_ctl.zero_xy = (xs == '0) && (ys == '0);
    pre_ctl.z_pos   = (zs > 0);
    pre_ctl.bypass  = (pre_y == '0);   // exact axis angle, no rotation needed
  end

  // ------------------------------------------------------------------
  // Pass one: (x, y) -> yaw angle and unscaled planar length; z rides along
  // ------------------------------------------------------------------
  ctl_t                 p1_ctl [0:N];
  logic signed [XW-1:0] p1_x   [0:N];
  logic signed [XW-1:0] p1_y   [0:N];
  logic [ANG_W-1:0]     p1_ang [0:N];
  logic [XW-1:0]        p1_z   [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl[0] <= '0;
    end else if (en) begin
      p1_ctl[0] <= pre_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x[0]   <= pre_x;
      p1_y[0]   <= pre_y;
      p1_ang[0] <= pre_ang;
      p1_z[0]   <= zs;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_pass1
    vtpy_cordic_stage #(
      .XW           (XW),
      .AUX_W        (XW),
      .SHIFT        (i),
      .HOLD_ON_ZERO (1'b0)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (p1_ctl[i]),
      .x_i   (p1_x[i]),
      .y_i   (p1_y[i]),
      .ang_i (p1_ang[i]),
      .aux_i (p1_z[i]),
      .ctl_o (p1_ctl[i+1]),
      .x_o   (p1_x[i+1]),
      .y_o   (p1_y[i+1]),
      .ang_o (p1_ang[i+1]),
      .aux_o (p1_z[i+1])
    );
  end

  // ------------------------------------------------------------------
  // Gain correction of the planar length (two stages)
  // ------------------------------------------------------------------
  ctl_t                 gc_ctl;
  logic signed [XW-1:0] gc_len;
  logic [ANG_W-1:0]     gc_yaw;
  logic [XW-1:0]        gc_z;

  vtpy_gain_comp #(
    .XW    (XW),
    .AUX_W (XW)
  ) u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (p1_ctl[N]),
    .x_i   (p1_x[N]),
    .ang_i (p1_ang[N]),
    .aux_i (p1_z[N]),
    .ctl_o (gc_ctl),
    .len_o (gc_len),
    .ang_o (gc_yaw),
    .aux_o (gc_z)
  );

  // ------------------------------------------------------------------
  // Pass two: (length, -z) -> pitch; a zero leg holds; yaw rides along
  // ------------------------------------------------------------------
  ctl_t                 p2_ctl [0:N];
  logic signed [XW-1:0] p2_x   [0:N];
  logic signed [XW-1:0] p2_y   [0:N];
  logic [ANG_W-1:0]     p2_ang [0:N];
  logic [ANG_W-1:0]     p2_yaw [0:N];

  assign p2_ctl[0] = gc_ctl;
  assign p2_x[0]   = gc_len;
  assign p2_y[0]   = -gc_z;
  assign p2_ang[0] = ANGLE_0;
  assign p2_yaw[0] = gc_yaw;

  for (genvar i = 0; i < N; i++) begin : g_pass2
    vtpy_cordic_stage #(
      .XW           (XW),
      .AUX_W        (ANG_W),
      .SHIFT        (i),
      .HOLD_ON_ZERO (1'b1)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (p2_ctl[i]),
      .x_i   (p2_x[i]),
      .y_i   (p2_y[i]),
      .ang_i (p2_ang[i]),
      .aux_i (p2_yaw[i]),
      .ctl_o (p2_ctl[i+1]),
      .x_o   (p2_x[i+1]),
      .y_o   (p2_y[i+1]),
      .ang_o (p2_ang[i+1]),
      .aux_o (p2_yaw[i+1])
    );
  end

  // ------------------------------------------------------------------
  // Scale to 1/256 degree
  // ------------------------------------------------------------------
  ctl_t             sc_ctl;
  logic [OUT_W-1:0] sc_pitch, sc_yaw;

  vtpy_angle_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (p2_ctl[N]),
    .pitch_ang_i (p2_ang[N]),
    .yaw_ang_i   (p2_yaw[N]),
    .ctl_o       (sc_ctl),
    .pitch_o     (sc_pitch),
    .yaw_o       (sc_yaw)
  );

  // ------------------------------------------------------------------
  // Output register plus skid entry
  // ------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] res_data;
  logic [OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic                   out_valid_r;
  logic                   push;

  assign res_data = {{(OUT_TDATA_W-2*OUT_W){1'b0}}, sc_yaw, sc_pitch};
  assign push     = en && sc_ctl.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (push) begin
      skid_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && skid_valid_r) |=> (skid_valid_r && $stable(skid_data_r)))
    else $error("skid entry lost during output stall");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[OUT_W-1:0] < OUT_FULL_CIRCLE))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[2*OUT_W-1:OUT_W] < OUT_FULL_CIRCLE))
    else $error("yaw out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("valid survives reset");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import vtpy_pkg::*;

  localparam int COMP_W     = 24;
  localparam int STAGES     = 24;
  localparam int IN_W       = ((3 * COMP_W + 7) / 8) * 8;
  localparam int LIMIT      = 400000;  // cycles
  localparam int LONG_HOLD  = 300;     // receiver hold-off, cycles
  localparam int PIPE_DEPTH = 2 * STAGES + 5;

  localparam logic signed [COMP_W-1:0] C_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] C_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  // in_tdata layout, lowest bits first: x, y, z
  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } vec_t;

  // out_tdata layout, lowest bits first: pitch, yaw
  typedef struct packed {
    logic [OUT_W-1:0] yaw;
    logic [OUT_W-1:0] pitch;
  } angles_t;

  logic            clk;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  vec_t    vec_q[$];      // requests waiting to be offered
  angles_t angles_q[$];   // predicted pitch/yaw, oldest first
  int      err_cnt        = 0;
  int      cycle_cnt      = 0;
  int      src_idle_pct   = 0;
  int      sink_stall_pct = 0;
  bit      sink_hold      = 1'b0;
  bit      in_taken       = 1'b0;  // request accepted at the last rising edge

  vector_to_pitch_yaw #(
    .COMPONENT_WIDTH(COMP_W),
    .CORDIC_STAGES  (STAGES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One vectoring pass: drives yr toward zero, sums the turned angle into acc.
  // With skip_zero a stage whose leg is already zero leaves everything alone.
  function automatic longint cordic_vector(inout longint xr, input longint yr,
                                           input longint acc, input bit skip_zero);
    longint dx, dy;
    for (int i = 0; i < STAGES; i++) begin
      if (!(skip_zero && yr == 0)) begin
        dx = xr >>> (i & 31);   // arithmetic, rounds toward minus infinity
        dy = yr >>> (i & 31);
        if (yr >= 0) begin
          xr  = xr + dy;
          yr  = yr - dx;
          acc = acc + longint'(ATAN_TAB[i & 31]);
        end else begin
          xr  = xr - dy;
          yr  = yr + dx;
          acc = acc - longint'(ATAN_TAB[i & 31]);
        end
      end
    end
    return acc;
  endfunction

  // binary angle (mod 2^32) to 1/256 degree, truncated
  function automatic logic [OUT_W-1:0] angle_to_units(longint acc);
    longint unsigned prod;
    prod = longint'(acc[31:0]) * longint'(OUT_FULL_CIRCLE);
    return prod[OUT_W+31:32];
  endfunction

  function automatic angles_t predict_angles(vec_t v);
    angles_t res;
    longint  x, y, z, t, len, yaw_acc, pitch_acc;
    x = longint'(v.x) <<< GUARD_BITS;
    y = longint'(v.y) <<< GUARD_BITS;
    z = longint'(v.z) <<< GUARD_BITS;
    if (x == 0 && y == 0) begin
      // straight up or down: fixed pitch, yaw zero
      res.pitch = (z > 0) ? PITCH_DOWN : PITCH_UP;
      res.yaw   = '0;
      return res;
    end
    // quadrant pre-rotation brings the vector into the right half plane
    if (y > 0) begin
      t = x; x = y; y = -t;
      yaw_acc = longint'(ANGLE_90);
    end else if (y < 0) begin
      t = x; x = -y; y = t;
      yaw_acc = -longint'(ANGLE_90);
    end else if (x < 0) begin
      x = -x;
      yaw_acc = longint'(ANGLE_180);
    end else begin
      yaw_acc = longint'(ANGLE_0);
    end
    if (y == 0) begin
      len = x;   // on an axis: exact yaw, no gain correction
    end else begin
      yaw_acc = cordic_vector(x, y, yaw_acc, 1'b0);
      len = (x * longint'(INV_GAIN_Q22)) >>> GAIN_FRAC;
    end
    pitch_acc = cordic_vector(len, -z, 0, 1'b1);
    res.pitch = angle_to_units(pitch_acc);
    res.yaw   = angle_to_units(yaw_acc);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  // Samples both channels at the rising edge, where the requests complete.
  always @(posedge clk) begin : monitor
    angles_t want, got;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) angles_q.push_back(predict_angles(vec_t'(in_tdata)));
    if (rst_n && out_tvalid && out_tready) begin
      got = angles_t'(out_tdata[2*OUT_W-1:0]);
      if (angles_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: pitch %0d yaw %0d",
                                  got.pitch, got.yaw));
      end else begin
        want = angles_q.pop_front();
        if (got.pitch !== want.pitch)
          report_mismatch($sformatf("pitch got %0d expected %0d", got.pitch, want.pitch));
        if (got.yaw !== want.yaw)
          report_mismatch($sformatf("yaw got %0d expected %0d", got.yaw, want.yaw));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both moving at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (vec_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= vec_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || sink_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_vec(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                          logic signed [COMP_W-1:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vec_q.push_back(v);
  endtask

  function automatic logic signed [COMP_W-1:0] rand_comp();
    int s;
    s = $urandom_range(64);
    case ($urandom_range(7))
      0: return C_MIN;
      1: return C_MAX;
      2: return COMP_W'(s - 32);    // near zero, both signs
      3: return '0;
      default: return COMP_W'($urandom());
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    v.x = rand_comp();
    v.y = rand_comp();
    v.z = rand_comp();
    case ($urandom_range(11))
      0: begin v.x = '0; v.y = '0; end       // pole
      1: v.y = '0;                           // on the x axis
      2: v.x = '0;                           // on the y axis
      3: v.z = '0;                           // level
      4: v.y = $urandom_range(1) ? v.x : -v.x;  // diagonal
      5: begin v.x = COMP_W'($urandom()); v.y = COMP_W'($urandom()); end
      default: ;
    endcase
    return v;
  endfunction

  // waits until every queued request is sent and every predicted result has come out
  task automatic drain();
    while (vec_q.size() != 0 || in_tvalid || angles_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int n);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) vec_q.push_back(rand_vec());
    drain();
  endtask

  initial begin : watchdog
    while (cycle_cnt < LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, axes, poles, level and diagonal vectors
    push_vec(C_MAX, C_MAX, C_MAX);
    push_vec(C_MIN, C_MIN, C_MIN);
    push_vec(C_MAX, 0, 0);
    push_vec(C_MIN, 0, 0);
    push_vec(0, C_MAX, 0);
    push_vec(0, C_MIN, 0);
    push_vec(0, 0, C_MAX);
    push_vec(0, 0, C_MIN);
    push_vec(0, 0, 0);
    push_vec(0, 0, 1);
    push_vec(0, 0, -1);
    push_vec(1, 0, 0);
    push_vec(-1, 0, 0);
    push_vec(0, 1, 0);
    push_vec(0, -1, 0);
    push_vec(5, 5, 0);
    push_vec(-7, 7, 3);
    push_vec(3, -3, -3);
    push_vec(C_MIN, C_MIN, 0);
    push_vec(C_MAX, C_MIN, C_MAX);
    push_vec(C_MIN, C_MAX, C_MIN);
    push_vec(1, 1, 1);
    push_vec(-1, -1, -1);
    push_vec(C_MIN, 0, C_MAX);
    drain();

    // full rate, with a long receiver hold-off partway through so the
    // pipeline backs up and in_tready drops
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (450) vec_q.push_back(rand_vec());
    fork
      begin
        repeat (40) @(posedge clk);
        sink_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    drain();

    run_phase(83, 0, 400);
    run_phase(0, 83, 400);
    run_phase(12, 12, 400);

    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (angles_q.size() != 0)
      report_mismatch($sformatf("%0d results never came out", angles_q.size()));
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
